[src/mte_pkg.sv]
// Shared types, op codes and helpers for the MIDI track event encoder.
package mte_pkg;

    localparam logic [2:0] OP_NOTE_ON   = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF  = 3'd1;
    localparam logic [2:0] OP_CTRL      = 3'd2;
    localparam logic [2:0] OP_PROGRAM   = 3'd3;
    localparam logic [2:0] OP_TIME_SIG  = 3'd4;
    localparam logic [2:0] OP_KEY_SIG   = 3'd5;
    localparam logic [2:0] OP_END_TRACK = 3'd6;

    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_CTRL      = 8'hB0;
    localparam logic [7:0] ST_PROGRAM   = 8'hC0;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] META_TS      = 8'h58;
    localparam logic [7:0] META_KS      = 8'h59;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] TS_LEN       = 8'h04;
    localparam logic [7:0] KS_LEN       = 8'h02;
    localparam logic [7:0] TS_CLOCKS    = 8'h18;
    localparam logic [7:0] TS_32NDS     = 8'h08;

    localparam logic [27:0] VLQ_LIM3 = 28'h01F_FFFF;
    localparam logic [27:0] VLQ_LIM2 = 28'h000_3FFF;
    localparam logic [27:0] VLQ_LIM1 = 28'h000_007F;

    // event descriptor queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  trk;
        logic [27:0] delta;
        logic [7:0]  status;   // first event byte: channel status or FF
        logic [7:0]  d1;
        logic [7:0]  d2;       // already forced/converted by the front end
    } t_evt;

    function automatic logic [7:0] floor_log2(input logic [7:0] d);
        logic [7:0] p;
        p = 8'd0;
        for (int i = 1; i < 8; i++) begin
            if (d[i]) p = 8'(i);
        end
        return p;
    endfunction

endpackage

[src/midi_track_event_encoder_unit.sv]
// Top level of the MIDI track event encoder.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  event in | in  | push / full        | i_op i_tick i_channel i_data_first/second
//  bytes out| out | empty / pop        | o_out_byte o_out_track o_last_byte
//
// One output byte per cycle from the serializer while pop keeps up; an event is
// 3 to 11 bytes (delta VLQ of 1 to 4 bytes plus 2 to 7 event bytes). The front end
// takes one request per cycle while the 4-entry descriptor queue has room.
// Synchronous reset clears the track in-use flags, the queue and the serializer.
// A stalled pop holds the output byte and stalls the serializer; the queue then
// fills, and full rises once it holds four requests.
module midi_track_event_encoder_unit #(
    parameter int TRACK_COUNT = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_tick,
    input  logic [4:0]  i_channel,
    input  logic [7:0]  i_data_first,
    input  logic [7:0]  i_data_second,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic [4:0]  o_out_track,
    output logic        o_last_byte
);
    import mte_pkg::*;

    logic q_push, q_full, q_valid, q_pop;
    t_evt q_in_evt, q_out_evt;

    mte_front #(
        .TRACK_COUNT(TRACK_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_op         (i_op),
        .i_tick       (i_tick),
        .i_channel    (i_channel),
        .i_data_first (i_data_first),
        .i_data_second(i_data_second),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_evt      (q_in_evt)
    );

    mte_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_evt  (q_in_evt),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_evt  (q_out_evt)
    );

    mte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_evt    (q_out_evt),
        .o_q_pop    (q_pop),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_out_track(o_out_track),
        .o_last_byte(o_last_byte)
    );

endmodule

[src/mte_front.sv]
// Front end: validates and classifies events, keeps per-track last tick.
module mte_front #(
    parameter int TRACK_COUNT = 17
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic [2:0]      i_op,
    input  logic [31:0]     i_tick,
    input  logic [4:0]      i_channel,
    input  logic [7:0]      i_data_first,
    input  logic [7:0]      i_data_second,
    input  logic            i_q_full,
    output logic            o_q_push,
    output mte_pkg::t_evt   o_q_evt
);
    import mte_pkg::*;

    localparam int         TW      = $clog2(TRACK_COUNT);
    localparam logic [4:0] TRK_LIM = 5'(TRACK_COUNT);

    logic [TRACK_COUNT-1:0] r_used;
    logic [31:0]            r_last_tick [TRACK_COUNT];

    logic          w_accept;
    logic          w_ch_ok;
    logic          w_is_chan;
    logic          w_is_meta;
    logic          w_is_eot;
    logic          w_valid;
    logic          w_wr;
    logic [4:0]    w_trk;
    logic [TW-1:0] w_idx;
    logic [31:0]   w_last;
    logic [31:0]   w_delta;

    assign full     = i_q_full;
    assign w_accept = push && !i_q_full;

    assign w_ch_ok   = i_channel < TRK_LIM;
    assign w_is_chan = i_op == OP_NOTE_ON || i_op == OP_NOTE_OFF ||
                       i_op == OP_CTRL || i_op == OP_PROGRAM;
    assign w_is_meta = i_op == OP_TIME_SIG || i_op == OP_KEY_SIG;
    assign w_is_eot  = i_op == OP_END_TRACK;

    assign w_trk  = w_is_meta ? 5'd0 : i_channel;
    assign w_idx  = w_trk[TW-1:0];
    // an unused entry reads as tick zero
    assign w_last = r_used[w_idx] ? r_last_tick[w_idx] : 32'd0;
    assign w_delta = i_tick - w_last;

    always_comb begin
        w_valid = 1'b0;
        if (w_is_chan) w_valid = w_ch_ok && (i_channel != 5'd0);
        else if (w_is_meta) w_valid = 1'b1;
        else if (w_is_eot) w_valid = w_ch_ok && r_used[w_idx];
    end

    assign w_wr     = w_accept && w_valid && !w_is_eot;
    assign o_q_push = w_accept && w_valid;

    always_comb begin
        o_q_evt.op     = i_op;
        o_q_evt.trk    = w_trk;
        o_q_evt.delta  = w_is_eot ? 28'd0 : w_delta[27:0];
        o_q_evt.d1     = i_data_first;
        o_q_evt.d2     = i_data_second;
        o_q_evt.status = ST_META;
        case (i_op)
            OP_NOTE_ON:  o_q_evt.status = ST_NOTE_ON | {4'd0, 4'(w_trk - 5'd1)};
            OP_NOTE_OFF: begin
                o_q_evt.status = ST_NOTE_OFF | {4'd0, 4'(w_trk - 5'd1)};
                o_q_evt.d2     = 8'd0;
            end
            OP_CTRL:     o_q_evt.status = ST_CTRL | {4'd0, 4'(w_trk - 5'd1)};
            OP_PROGRAM:  o_q_evt.status = ST_PROGRAM | {4'd0, 4'(w_trk - 5'd1)};
            OP_TIME_SIG: o_q_evt.d2 = floor_log2(i_data_second);
            default:     o_q_evt.status = ST_META;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (w_wr) begin
            r_used[w_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_last_tick[w_idx] <= i_tick;
        end
    end

    a_used_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> r_used[$past(w_idx)])
        else $error("track not marked in use after event");

    a_eot_needs_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && w_is_eot) |-> r_used[w_idx])
        else $error("end of track queued for unused track");

endmodule

[src/mte_queue.sv]
// Short descriptor queue between front end and serializer.
module mte_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mte_pkg::t_evt   i_evt,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mte_pkg::t_evt   o_evt
);
    import mte_pkg::*;

    t_evt            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_count,  n_count;

    logic w_push, w_pop;

    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_evt   = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) n_count = r_count + 1'b1;
        else if (!w_push && w_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_evt;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request pushed into full queue");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != (Q_AW+1)'(Q_DEPTH)) |-> (Q_AW'(r_count) == Q_AW'(r_wr_ptr - r_rd_ptr)))
        else $error("queue count out of step with pointers");

endmodule

[src/mte_back.sv]
// Serializer: turns one descriptor into delta VLQ bytes and event bytes.
module mte_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  mte_pkg::t_evt   i_q_evt,
    output logic            o_q_pop,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      o_out_byte,
    output logic [4:0]      o_out_track,
    output logic            o_last_byte
);
    import mte_pkg::*;

    logic       r_busy;
    t_evt       r_evt;
    logic [2:0] r_nv;
    logic [3:0] r_total;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [4:0] r_out_track;
    logic       r_out_last;

    logic       w_can_out, w_fire, w_fin;
    logic [2:0] w_ld_nv;
    logic [3:0] w_ld_body;
    logic [3:0] w_body_idx;
    logic [1:0] w_grp;
    logic [7:0] w_byte;

    assign w_can_out = !r_out_valid || pop;
    assign w_fire    = r_busy && w_can_out;
    assign w_fin     = w_fire && (r_idx == r_total - 4'd1);
    assign o_q_pop   = i_q_valid && (!r_busy || w_fin);

    // sizes of the incoming descriptor
    always_comb begin
        if (i_q_evt.delta > VLQ_LIM3)      w_ld_nv = 3'd4;
        else if (i_q_evt.delta > VLQ_LIM2) w_ld_nv = 3'd3;
        else if (i_q_evt.delta > VLQ_LIM1) w_ld_nv = 3'd2;
        else                               w_ld_nv = 3'd1;
        case (i_q_evt.op)
            OP_PROGRAM:  w_ld_body = 4'd2;
            OP_TIME_SIG: w_ld_body = 4'd7;
            OP_KEY_SIG:  w_ld_body = 4'd5;
            default:     w_ld_body = 4'd3;
        endcase
    end

    // current byte: VLQ groups high first, then the event body
    always_comb begin
        w_grp      = 2'(r_nv - 3'd1 - r_idx[2:0]);
        w_body_idx = r_idx - {1'b0, r_nv};
        w_byte     = 8'd0;
        if (r_idx < {1'b0, r_nv}) begin
            case (w_grp)
                2'd3:    w_byte = {1'b1, r_evt.delta[27:21]};
                2'd2:    w_byte = {1'b1, r_evt.delta[20:14]};
                2'd1:    w_byte = {1'b1, r_evt.delta[13:7]};
                default: w_byte = {1'b0, r_evt.delta[6:0]};
            endcase
        end else if (w_body_idx == 4'd0) begin
            w_byte = r_evt.status;
        end else begin
            case (r_evt.op)
                OP_TIME_SIG: begin
                    case (w_body_idx)
                        4'd1:    w_byte = META_TS;
                        4'd2:    w_byte = TS_LEN;
                        4'd3:    w_byte = r_evt.d1;
                        4'd4:    w_byte = r_evt.d2;
                        4'd5:    w_byte = TS_CLOCKS;
                        default: w_byte = TS_32NDS;
                    endcase
                end
                OP_KEY_SIG: begin
                    case (w_body_idx)
                        4'd1:    w_byte = META_KS;
                        4'd2:    w_byte = KS_LEN;
                        4'd3:    w_byte = r_evt.d1;
                        default: w_byte = r_evt.d2;
                    endcase
                end
                OP_END_TRACK: w_byte = (w_body_idx == 4'd1) ? META_EOT : 8'd0;
                default:      w_byte = (w_body_idx == 4'd1) ? r_evt.d1 : r_evt.d2;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end else if (w_fire) begin
                r_idx <= r_idx + 4'd1;
            end
            if (w_fire) r_out_valid <= 1'b1;
            else if (pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_evt   <= i_q_evt;
            r_nv    <= w_ld_nv;
            r_total <= {1'b0, w_ld_nv} + w_ld_body;
        end
        if (w_fire) begin
            r_out_byte  <= w_byte;
            r_out_track <= r_evt.trk;
            r_out_last  <= w_fin;
        end
    end

    assign empty       = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_track = r_out_track;
    assign o_last_byte = r_out_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_total && r_total <= 4'd11))
        else $error("byte index past end of event");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (!r_busy || w_fin))
        else $error("descriptor loaded while serializer busy");

endmodule

[tb/tb_midi_track_event_encoder_unit.sv]
// Testbench for the MIDI track event encoder: directed and random events checked byte by byte.
module tb_midi_track_event_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mte_pkg::*;

    localparam int TRACKS = 17;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_FROM = 500;
    localparam int QUIET_TO = 1100;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] tick;
        logic [4:0]  chan;
        logic [7:0]  d1;
        logic [7:0]  d2;
    } midi_event_t;

    typedef struct {
        logic [7:0] data;
        logic [4:0] trk;
        logic       last;
    } track_byte_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_op = '0;
    logic [31:0] i_tick = '0;
    logic [4:0]  i_channel = '0;
    logic [7:0]  i_data_first = '0;
    logic [7:0]  i_data_second = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic [4:0]  o_out_track;
    logic        o_last_byte;

    midi_event_t pending_events[$];
    track_byte_t expected_bytes[$];
    logic [31:0] last_tick[TRACKS];
    logic        track_used[TRACKS];

    int cycle_count = 0;
    int accepted_count = 0;
    int silent_count = 0;
    int checked_count = 0;
    int mismatch_count = 0;

    logic calm;
    assign calm = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    midi_track_event_encoder_unit #(
        .TRACK_COUNT(TRACKS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_op(i_op),
        .i_tick(i_tick),
        .i_channel(i_channel),
        .i_data_first(i_data_first),
        .i_data_second(i_data_second),
        .empty(empty),
        .pop(pop),
        .o_out_byte(o_out_byte),
        .o_out_track(o_out_track),
        .o_last_byte(o_last_byte)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, expected_bytes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TRACKS; i++) begin
            last_tick[i] = '0;
            track_used[i] = 1'b0;
        end
    end

    function automatic void put_track_byte(input logic [7:0] data, input logic [4:0] trk,
                                           input logic last);
        track_byte_t tb_byte;
        tb_byte.data = data;
        tb_byte.trk = trk;
        tb_byte.last = last;
        expected_bytes.push_back(tb_byte);
    endfunction

    // Appends the bytes an event produces; returns how many.
    function automatic int encode_event(input midi_event_t ev);
        logic [4:0]  trk;
        logic [31:0] full_delta;
        logic [27:0] delta;
        logic [3:0]  nib;
        logic [7:0]  denom_log;
        int          start_size;
        start_size = expected_bytes.size();
        if (ev.op == OP_END_TRACK) begin
            if (ev.chan >= TRACKS || !track_used[ev.chan])
                return 0;
            put_track_byte(8'h00, ev.chan, 1'b0);
            put_track_byte(ST_META, ev.chan, 1'b0);
            put_track_byte(META_EOT, ev.chan, 1'b0);
            put_track_byte(8'h00, ev.chan, 1'b1);
            return 4;
        end
        if (ev.op <= OP_PROGRAM) begin
            if (ev.chan == 0 || ev.chan >= TRACKS)
                return 0;
            trk = ev.chan;
        end else if (ev.op == OP_TIME_SIG || ev.op == OP_KEY_SIG) begin
            trk = 5'd0;
        end else begin
            return 0;
        end

        full_delta = ev.tick - last_tick[trk];
        delta = full_delta[27:0];
        if (delta > 28'h01F_FFFF)
            put_track_byte({1'b1, delta[27:21]}, trk, 1'b0);
        if (delta > 28'h000_3FFF)
            put_track_byte({1'b1, delta[20:14]}, trk, 1'b0);
        if (delta > 28'h000_007F)
            put_track_byte({1'b1, delta[13:7]}, trk, 1'b0);
        put_track_byte({1'b0, delta[6:0]}, trk, 1'b0);
        last_tick[trk] = ev.tick;
        track_used[trk] = 1'b1;
        nib = 4'(trk - 5'd1);

        denom_log = 8'd0;
        for (int i = 1; i < 8; i++) begin
            if (ev.d2[i])
                denom_log = 8'(i);
        end

        case (ev.op)
            OP_NOTE_ON: begin
                put_track_byte(ST_NOTE_ON | {4'h0, nib}, trk, 1'b0);
                put_track_byte(ev.d1, trk, 1'b0);
                put_track_byte(ev.d2, trk, 1'b1);
            end
            OP_NOTE_OFF: begin
                put_track_byte(ST_NOTE_OFF | {4'h0, nib}, trk, 1'b0);
                put_track_byte(ev.d1, trk, 1'b0);
                put_track_byte(8'h00, trk, 1'b1);
            end
            OP_CTRL: begin
                put_track_byte(ST_CTRL | {4'h0, nib}, trk, 1'b0);
                put_track_byte(ev.d1, trk, 1'b0);
                put_track_byte(ev.d2, trk, 1'b1);
            end
            OP_PROGRAM: begin
                put_track_byte(ST_PROGRAM | {4'h0, nib}, trk, 1'b0);
                put_track_byte(ev.d1, trk, 1'b1);
            end
            OP_TIME_SIG: begin
                put_track_byte(ST_META, trk, 1'b0);
                put_track_byte(META_TS, trk, 1'b0);
                put_track_byte(TS_LEN, trk, 1'b0);
                put_track_byte(ev.d1, trk, 1'b0);
                put_track_byte(denom_log, trk, 1'b0);
                put_track_byte(TS_CLOCKS, trk, 1'b0);
                put_track_byte(TS_32NDS, trk, 1'b1);
            end
            default: begin
                put_track_byte(ST_META, trk, 1'b0);
                put_track_byte(META_KS, trk, 1'b0);
                put_track_byte(KS_LEN, trk, 1'b0);
                put_track_byte(ev.d1, trk, 1'b0);
                put_track_byte(ev.d2, trk, 1'b1);
            end
        endcase
        return expected_bytes.size() - start_size;
    endfunction

    // Request driver: holds a request while full, otherwise idles at random.
    always @(posedge i_clk) begin : event_driver
        logic        go;
        midi_event_t nxt;
        if (push && !full)
            pending_events.delete(0);
        if (push && full)
            go = 1'b1;
        else
            go = i_rst_n && pending_events.size() > 0 &&
                 (calm || $urandom_range(0, 99) >= 35);
        if (go) begin
            nxt = pending_events[0];
        end else begin
            nxt.op = 3'($urandom);
            nxt.tick = $urandom;
            nxt.chan = 5'($urandom);
            nxt.d1 = 8'($urandom);
            nxt.d2 = 8'($urandom);
        end
        push <= go;
        i_op <= nxt.op;
        i_tick <= nxt.tick;
        i_channel <= nxt.chan;
        i_data_first <= nxt.d1;
        i_data_second <= nxt.d2;
    end

    always @(posedge i_clk) begin
        pop <= i_rst_n && (calm || $urandom_range(0, 99) >= 35);
    end

    always @(posedge i_clk) begin : byte_monitor
        midi_event_t taken;
        track_byte_t want;
        if (i_rst_n) begin
            if (push && !full) begin
                taken.op = i_op;
                taken.tick = i_tick;
                taken.chan = i_channel;
                taken.d1 = i_data_first;
                taken.d2 = i_data_second;
                accepted_count++;
                if (encode_event(taken) == 0)
                    silent_count++;
            end
            if (pop && !empty) begin
                checked_count++;
                if (expected_bytes.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: unexpected byte %02h track %0d last %0b", $realtime,
                                 o_out_byte, o_out_track, o_last_byte);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data || o_out_track !== want.trk ||
                        o_last_byte !== want.last) begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("%0t: byte %0d expected %02h/%0d/%0b got %02h/%0d/%0b",
                                     $realtime, checked_count, want.data, want.trk,
                                     want.last, o_out_byte, o_out_track, o_last_byte);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic queue_event(input logic [2:0] op, input logic [31:0] tick,
                               input logic [4:0] chan, input logic [7:0] d1,
                               input logic [7:0] d2);
        midi_event_t ev;
        ev.op = op;
        ev.tick = tick;
        ev.chan = chan;
        ev.d1 = d1;
        ev.d2 = d2;
        pending_events.push_back(ev);
    endtask

    initial begin : stimulus
        logic [31:0] gen_tick;
        logic [4:0]  chan;
        logic [2:0]  op;
        int          pick;
        int          real_count;

        // unused tracks, bad track numbers, op 7
        queue_event(OP_END_TRACK, 32'd0, 5'd5, 8'h00, 8'h00);
        queue_event(OP_END_TRACK, 32'd0, 5'd0, 8'h00, 8'h00);
        queue_event(OP_NOTE_ON, 32'd10, 5'd0, 8'h40, 8'h40);
        queue_event(OP_NOTE_ON, 32'd10, 5'd17, 8'h40, 8'h40);
        queue_event(OP_CTRL, 32'd10, 5'd31, 8'h40, 8'h40);
        queue_event(OP_UNUSED, 32'd10, 5'd1, 8'h40, 8'h40);
        // delta length boundaries
        queue_event(OP_NOTE_ON, 32'h0000_0000, 5'd1, 8'h00, 8'h00);
        queue_event(OP_NOTE_ON, 32'h0000_007F, 5'd16, 8'hFF, 8'hFF);
        queue_event(OP_NOTE_OFF, 32'h0000_0080, 5'd1, 8'h3C, 8'hFF);
        queue_event(OP_CTRL, 32'h0000_3FFF, 5'd2, 8'h07, 8'h7F);
        queue_event(OP_PROGRAM, 32'h0000_4000, 5'd3, 8'h05, 8'hAA);
        queue_event(OP_PROGRAM, 32'h0020_4000, 5'd3, 8'hFF, 8'h00);
        queue_event(OP_NOTE_ON, 32'h001F_FFFF, 5'd4, 8'h55, 8'h2A);
        // meta events ignore the channel; denominators 0, 1, 2, 255, 64
        queue_event(OP_TIME_SIG, 32'h0FFF_FFFF, 5'd31, 8'h04, 8'h00);
        queue_event(OP_TIME_SIG, 32'h0FFF_FFFF, 5'd0, 8'h03, 8'h01);
        queue_event(OP_TIME_SIG, 32'h1000_0000, 5'd9, 8'h06, 8'h02);
        queue_event(OP_TIME_SIG, 32'hFFFF_FFFF, 5'd16, 8'hFF, 8'hFF);
        // tick wraps, then a delta with high bits to drop
        queue_event(OP_KEY_SIG, 32'h0000_0005, 5'd0, 8'hFB, 8'h01);
        queue_event(OP_KEY_SIG, 32'h8000_0000, 5'd0, 8'h07, 8'h00);
        queue_event(OP_TIME_SIG, 32'h8000_0000, 5'd0, 8'h02, 8'h40);
        queue_event(OP_END_TRACK, 32'h0000_FFFF, 5'd1, 8'hFF, 8'hFF);
        queue_event(OP_END_TRACK, 32'h0000_0000, 5'd0, 8'h00, 8'h00);
        queue_event(OP_END_TRACK, 32'h0000_0000, 5'd17, 8'h00, 8'h00);
        // end of track leaves the last tick alone
        queue_event(OP_NOTE_ON, 32'h0000_0100, 5'd1, 8'h3C, 8'h64);

        gen_tick = 32'h0000_0100;
        real_count = 0;
        while (real_count < 65) begin
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    gen_tick += $urandom_range(0, 127);
                else if (pick < 65)
                    gen_tick += $urandom_range(128, 32'h3FFF);
                else if (pick < 80)
                    gen_tick += $urandom_range(32'h4000, 32'h1F_FFFF);
                else if (pick < 92)
                    gen_tick += $urandom_range(32'h20_0000, 32'hFFF_FFFF);
                else
                    gen_tick = $urandom;
            end
            pick = $urandom_range(0, 99);
            chan = 5'($urandom_range(1, 16));
            if (pick < 20)
                op = OP_NOTE_ON;
            else if (pick < 35)
                op = OP_NOTE_OFF;
            else if (pick < 50)
                op = OP_CTRL;
            else if (pick < 60)
                op = OP_PROGRAM;
            else if (pick < 70)
                op = OP_TIME_SIG;
            else if (pick < 78)
                op = OP_KEY_SIG;
            else if (pick < 86) begin
                op = OP_END_TRACK;
                chan = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                    : 5'($urandom_range(0, 16));
            end else if (pick < 94) begin
                op = 3'($urandom_range(0, 3));
                chan = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
            end else begin
                op = OP_UNUSED;
                chan = 5'($urandom);
            end
            if (op == OP_TIME_SIG || op == OP_KEY_SIG)
                chan = 5'($urandom);
            queue_event(op, gen_tick, chan, 8'($urandom), 8'($urandom));
            if (op != OP_UNUSED && !(op <= OP_PROGRAM && (chan == 0 || chan >= TRACKS)) &&
                !(op == OP_END_TRACK && chan >= TRACKS))
                real_count++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_events.size() != 0 || push)
            @(posedge i_clk);
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_bytes.size() != 0)
            $display("%0d expected bytes never arrived", expected_bytes.size());
        $display("Accepted %0d events (%0d produced no bytes), checked %0d bytes, %0d mismatches",
                 accepted_count, silent_count, checked_count, mismatch_count);
        $display("Covered all ops, 1 to 4 byte deltas, tick wrap, unused and invalid tracks");
        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
